// File: rtl/core/tsag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_pkg
// Shared types and constants of the tile sprite address generator.
// ----------------------------------------------------------------------------
package tsag_pkg;

	// Descriptor size codes, taken from bits 7..4 of the size word.
	typedef enum logic [3:0] {
		SZ_2X2  = 4'h0,
		SZ_4X4  = 4'h4,
		SZ_2X32 = 4'h8,
		SZ_4X32 = 4'hC
	} size_code_t;

	// Y origins of the size codes.
	localparam logic [8:0] ORG_SMALL = 9'h100;
	localparam logic [8:0] ORG_NARROW = 9'h130;
	localparam logic [8:0] ORG_WIDE = 9'h120;

	// Configuration register indexes.
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 9;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	localparam cfg_addr_t CFG_FLIP_SCREEN = 2'd0;
	localparam cfg_addr_t CFG_SCREEN_MAX_X = 2'd1;
	localparam cfg_addr_t CFG_SCREEN_MAX_Y = 2'd2;

	// Reset values of the mirror origins.
	localparam logic [8:0] MAX_X_RESET = 9'd248;
	localparam logic [8:0] MAX_Y_RESET = 9'd216;

endpackage

// File: rtl/core/tsag_desc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_desc_if
// Descriptor channel: one sprite descriptor and a tile row per word.
// ----------------------------------------------------------------------------
interface tsag_desc_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_word;
	logic [15:0] xbank_word;
	logic [15:0] size_word;
	logic [4:0]  row_index;

	modport source (output valid, output pos_word, output xbank_word,
		output size_word, output row_index, input ready);
	modport sink (input valid, input pos_word, input xbank_word,
		input size_word, input row_index, output ready);
endinterface

// File: rtl/core/tsag_cell_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_cell_if
// Cell channel: one tile cell of a sprite row per word.
// ----------------------------------------------------------------------------
interface tsag_cell_if;
	logic              valid;
	logic              ready;
	logic [14:0]       tile_ram_addr;
	logic signed [9:0] screen_x;
	logic signed [9:0] screen_y;
	logic [3:0]        tile_bank;
	logic              invert_flip_x;
	logic              invert_flip_y;
	logic              last_in_row;

	modport source (output valid, output tile_ram_addr, output screen_x,
		output screen_y, output tile_bank, output invert_flip_x,
		output invert_flip_y, output last_in_row, input ready);
	modport sink (input valid, input tile_ram_addr, input screen_x,
		input screen_y, input tile_bank, input invert_flip_x,
		input invert_flip_y, input last_in_row, output ready);
endinterface

// File: rtl/core/tsag_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_cfg_if
// Configuration write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface tsag_cfg_if
	import tsag_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// File: rtl/core/tile_sprite_address_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_address_generator
// Expands one sprite descriptor row into its tile cells: tile RAM address,
// screen position, bank and flip inversion for each cell.
// ----------------------------------------------------------------------------
//  channel  role   words
//  desc     sink   one descriptor and tile row
//  tile     source one tile cell, 2 or 4 per descriptor word
//  cfg      sink   register write, always ready
//
//  A descriptor is decoded into the item register, then, while the tile
//  channel is not stalled, one cell a cycle is built from it into the output
//  register: 2 cells for 2-wide sizes, 4 for 4-wide sizes. The next descriptor
//  is taken in the cycle its predecessor hands over its last cell. Unknown
//  sizes and rows past the height are taken and give nothing.
//  Reset clears valids and restores the config registers; a stalled cell holds.
// ----------------------------------------------------------------------------
module tile_sprite_address_generator
	import tsag_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tsag_desc_if.sink   desc,
	tsag_cell_if.source tile,
	tsag_cfg_if.sink    cfg
);

	// Configuration registers.
	logic       flip_q;
	logic [8:0] max_x_q;
	logic [8:0] max_y_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q  <= 1'b0;
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				CFG_FLIP_SCREEN:  flip_q  <= cfg.data[0];
				CFG_SCREEN_MAX_X: max_x_q <= cfg.data;
				CFG_SCREEN_MAX_Y: max_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Descriptor decode.
	logic       shape_ok;
	logic       wide;
	logic [5:0] height;
	logic [8:0] origin;
	logic [8:0] ybase;

	always_comb begin
		shape_ok = 1'b1;
		wide     = 1'b0;
		height   = 6'd2;
		origin   = ORG_SMALL;
		case (desc.size_word[7:4])
			SZ_2X2: begin
				height = 6'd2;
			end
			SZ_4X4: begin
				wide   = 1'b1;
				height = 6'd4;
			end
			SZ_2X32: begin
				height = 6'd32;
				origin = ORG_NARROW;
			end
			SZ_4X32: begin
				wide   = 1'b1;
				height = 6'd32;
				origin = ORG_WIDE;
			end
			default: shape_ok = 1'b0;
		endcase
		if ({1'b0, desc.row_index} >= height)
			shape_ok = 1'b0;
		ybase = origin - {1'b0, desc.pos_word[7:0]} - {height, 3'b000};
	end

	// Item register, one descriptor row being expanded.
	logic              busy_s1;
	logic              wide_s1;
	logic              colflip_s1;
	logic [4:0]        page_s1;
	logic [4:0]        col0_s1;
	logic [4:0]        row_s1;
	logic [3:0]        bank_s1;
	logic signed [9:0] xbase_s1;
	logic [7:0]        sy_s1;
	logic [1:0]        cell_q;

	// Output register.
	logic              valid_s2;
	logic [14:0]       addr_s2;
	logic signed [9:0] sx_s2;
	logic signed [9:0] sy_s2;
	logic [3:0]        bank_s2;
	logic              fx_s2;
	logic              fy_s2;
	logic              last_s2;

	logic       load;
	logic       advance;
	logic       last_cell;
	logic       accept;
	logic [1:0] last_idx;
	logic [1:0] tx;
	logic [4:0] col;
	logic [9:0] sx_raw;
	logic [9:0] sx_out;
	logic [9:0] sy_out;

	assign load      = !valid_s2 || tile.ready;
	assign advance   = load && busy_s1;
	assign last_idx  = wide_s1 ? 2'd3 : 2'd1;
	assign last_cell = (cell_q == last_idx);
	assign desc.ready = !busy_s1 || (advance && last_cell);
	assign accept    = desc.valid && desc.ready;

	// Cell datapath. In 4-wide sizes the column flip reverses source order.
	assign tx     = colflip_s1 ? (last_idx - cell_q) : cell_q;
	assign col    = col0_s1 + {3'b000, tx};
	assign sx_raw = xbase_s1 + {5'b00000, cell_q, 3'b000};
	assign sx_out = flip_q ? ({1'b0, max_x_q} - sx_raw) : sx_raw;
	assign sy_out = flip_q ? ({1'b0, max_y_q} - {2'b00, sy_s1}) : {2'b00, sy_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1  <= 1'b0;
			cell_q   <= 2'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				busy_s1 <= shape_ok;
			else if (advance && last_cell)
				busy_s1 <= 1'b0;
			if (accept || (advance && last_cell))
				cell_q <= 2'd0;
			else if (advance)
				cell_q <= cell_q + 2'd1;
			if (load)
				valid_s2 <= busy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wide_s1    <= wide;
			colflip_s1 <= wide & desc.pos_word[8];
			page_s1    <= {1'b0, desc.pos_word[15:12]} + {desc.xbank_word[9], 4'b0000};
			col0_s1    <= wide ? {desc.pos_word[11:9], 2'b00} : {desc.pos_word[11:8], 1'b0};
			row_s1     <= {desc.size_word[3:0], 1'b0} + desc.row_index;
			bank_s1    <= desc.xbank_word[15:12];
			xbase_s1   <= {desc.xbank_word[8], desc.xbank_word[8:0]};
			sy_s1      <= ybase[7:0] + {desc.row_index, 3'b000};
		end
		if (advance) begin
			addr_s2 <= {page_s1, col, row_s1};
			sx_s2   <= sx_out;
			sy_s2   <= sy_out;
			bank_s2 <= bank_s1;
			fx_s2   <= colflip_s1 ^ flip_q;
			fy_s2   <= flip_q;
			last_s2 <= last_cell;
		end
	end

	assign tile.valid         = valid_s2;
	assign tile.tile_ram_addr = addr_s2;
	assign tile.screen_x      = sx_s2;
	assign tile.screen_y      = sy_s2;
	assign tile.tile_bank     = bank_s2;
	assign tile.invert_flip_x = fx_s2;
	assign tile.invert_flip_y = fy_s2;
	assign tile.last_in_row   = last_s2;

`ifndef SYNTHESIS
	// A 2-wide row never walks past its second cell.
	a_narrow_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && !wide_s1) |-> (cell_q <= 2'd1))
		else $error("cell counter past end of 2-wide row");

	// A well-formed descriptor starts its row at the first cell.
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && shape_ok) |=> (busy_s1 && cell_q == 2'd0))
		else $error("row did not start at first cell");

	// A descriptor is taken during a row only as its last cell moves out.
	a_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && busy_s1) |-> (advance && last_cell))
		else $error("descriptor taken while row still open");

	// The last cell word closes the row.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_cell && !accept) |=> !busy_s1)
		else $error("row still open after its last cell");
`endif

endmodule
